// ===== rtl/core/byte_crc8_crc16_engine_assert.svh =====
// Assertion macros shared by the CRC engine RTL.
// Needs no other file; the macros compile away under SYNTHESIS.
`ifndef BYTE_CRC8_CRC16_ENGINE_ASSERT_SVH
`define BYTE_CRC8_CRC16_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define BCCE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BCCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BCCE_ASSERT(lbl, clk, rst, prop, msg)
`define BCCE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/bcce_pkg.sv =====
// Shared types and constants for the byte CRC-8 / CRC-16 engine.
// No dependencies; imported by bcce_fold and the top level.
`default_nettype none

package bcce_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CRC_W  = 16;
   localparam int unsigned IDX_W  = 2;

   typedef enum logic [IDX_W-1:0] {
      REG_WIDTH_MODE = 2'd0,
      REG_POLYNOMIAL = 2'd1,
      REG_INIT_VALUE = 2'd2,
      REG_FINAL_XOR  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic             wide;
      logic [CRC_W-1:0] poly;
   } crc_cfg_type;

   localparam logic [CRC_W-1:0] POLY_RESET = 16'h0007;
   localparam logic [CRC_W-1:0] INIT_RESET = 16'h0000;
   localparam logic [CRC_W-1:0] FXOR_RESET = 16'h0000;

endpackage

`default_nettype wire

// ===== rtl/core/byte_crc8_crc16_engine.sv =====
// Byte-wide CRC-8 / CRC-16 engine, MSB first, non-reflected.
// Depends on bcce_pkg, bcce_fold and byte_crc8_crc16_engine_assert.svh.
//
// Usage:
//   req_*  carries one message byte per transfer; req_tlast marks the last byte.
//   rsp_*  carries one finished CRC per message, after the final XOR; the upper
//          byte is zero in 8-bit mode.
//   csr_*  writes width mode, polynomial, init value and final XOR by index;
//          write only while no message byte is in flight.
// Timing:
//   A byte is registered on acceptance; a non-last byte is folded in the next
//   cycle, a last byte once the result register is free. The fold updates the
//   running CRC and, for a last byte, registers the result that rsp_* presents.
//   One byte per cycle is sustained unless a last byte waits behind an untaken
//   result; the eight XOR-shift steps of the fold are the critical path.
// Reset: configuration returns to CRC-8, polynomial 0x07, init 0, final XOR 0;
//   the running CRC clears and no result is pending.
// Stall: a pending result holds on rsp_*; non-last bytes keep flowing, and
//   req_tready drops only when a last byte waits behind an untaken result.
`default_nettype none

module byte_crc8_crc16_engine
   import bcce_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   input  wire [BYTE_W-1:0]  req_tdata,   // [7:0] data_byte
   input  wire               req_tlast,   // last_byte
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [CRC_W-1:0]  rsp_tdata,   // [15:0] crc_value
   input  wire               csr_we,
   input  wire [IDX_W-1:0]   csr_index,
   input  wire [CRC_W-1:0]   csr_wdata
);

`include "byte_crc8_crc16_engine_assert.svh"

   logic              width_mode_ff;
   logic [CRC_W-1:0]  polynomial_ff;
   logic [CRC_W-1:0]  init_value_ff;
   logic [CRC_W-1:0]  final_xor_ff;

   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_last_ff;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CRC_W-1:0]  rsp_crc_ff;

   crc_cfg_type       fold_cfg;
   logic [CRC_W-1:0]  fold_crc;
   logic [CRC_W-1:0]  load_value;
   logic [CRC_W-1:0]  fxor_value;
   logic              s1_advance;
   logic              s1_emit;
   logic              req_xfer;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_mode_ff <= 1'b0;
         polynomial_ff <= POLY_RESET;
         init_value_ff <= INIT_RESET;
         final_xor_ff  <= FXOR_RESET;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_WIDTH_MODE: width_mode_ff <= csr_wdata[0];
            REG_POLYNOMIAL: polynomial_ff <= csr_wdata;
            REG_INIT_VALUE: init_value_ff <= csr_wdata;
            REG_FINAL_XOR:  final_xor_ff  <= csr_wdata;
         endcase
      end
   end

   assign fold_cfg = '{wide: width_mode_ff, poly: polynomial_ff};

   bcce_fold u_fold (
      .cfg_i  (fold_cfg),
      .crc_i  (crc_ff),
      .data_i (s1_byte_ff),
      .crc_o  (fold_crc)
   );

   assign load_value = width_mode_ff ? init_value_ff
                                     : {{(CRC_W-BYTE_W){1'b0}}, init_value_ff[BYTE_W-1:0]};
   assign fxor_value = width_mode_ff ? final_xor_ff
                                     : {{(CRC_W-BYTE_W){1'b0}}, final_xor_ff[BYTE_W-1:0]};

   // a last byte may only leave stage 1 when the result register is free
   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign s1_emit    = s1_advance && s1_last_ff;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_emit || (rsp_valid_ff && !rsp_tready);

   always_comb begin
      crc_in = crc_ff;
      if (s1_advance) begin
         crc_in = s1_last_ff ? load_value : fold_crc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= INIT_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (s1_emit) begin
         rsp_crc_ff <= fold_crc ^ fxor_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_crc_ff;

   `BCCE_ASSERT(a_rsp_from_last, clock, reset,
      $rose(rsp_tvalid) |-> $past(s1_valid_ff && s1_last_ff), "result without a last byte")
   `BCCE_ASSERT(a_reload_after_last, clock, reset,
      s1_emit |=> crc_ff == $past(load_value), "running CRC not reloaded after last byte")
   `BCCE_ASSERT(a_stall_cause, clock, reset,
      !req_tready |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_tready),
      "input stalled without a blocked result")
   `BCCE_ASSERT_ALWAYS(a_reset_clears, clock,
      reset |=> (!rsp_tvalid && req_tready), "pipeline not empty after reset")

endmodule

`default_nettype wire

// ===== rtl/core/bcce_fold.sv =====
// Folds one byte into the running CRC, MSB first, eight XOR-shift steps.
// Depends on bcce_pkg for widths and the configuration struct.
`default_nettype none

module bcce_fold
   import bcce_pkg::*;
(
   input  wire crc_cfg_type      cfg_i,
   input  wire [CRC_W-1:0]       crc_i,
   input  wire [BYTE_W-1:0]      data_i,
   output logic [CRC_W-1:0]      crc_o
);

   logic [BYTE_W-1:0] c8;
   logic [CRC_W-1:0]  c16;

   always_comb begin
      c8  = crc_i[BYTE_W-1:0] ^ data_i;
      c16 = crc_i ^ {data_i, {(CRC_W-BYTE_W){1'b0}}};
      for (int b = 0; b < BYTE_W; b++) begin
         c8  = c8[BYTE_W-1] ? ({c8[BYTE_W-2:0], 1'b0} ^ cfg_i.poly[BYTE_W-1:0])
                            : {c8[BYTE_W-2:0], 1'b0};
         c16 = c16[CRC_W-1] ? ({c16[CRC_W-2:0], 1'b0} ^ cfg_i.poly)
                            : {c16[CRC_W-2:0], 1'b0};
      end
      crc_o = cfg_i.wide ? c16 : {{(CRC_W-BYTE_W){1'b0}}, c8};
   end

endmodule

`default_nettype wire

// ===== dv/tb_byte_crc8_crc16_engine.sv =====
// Self-checking testbench for byte_crc8_crc16_engine: directed and random byte streams,
// with a CRC-8/CRC-16 predictor and random flow control on both streams.
// Depends on bcce_pkg and the byte_crc8_crc16_engine RTL.
`timescale 1ns / 100ps

module tb_byte_crc8_crc16_engine
   import bcce_pkg::*;
();

   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 80;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [BYTE_W-1:0]  req_tdata  = '0;
   logic               req_tlast  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [CRC_W-1:0]   rsp_tdata;
   logic               csr_we     = 1'b0;
   logic [IDX_W-1:0]   csr_index  = '0;
   logic [CRC_W-1:0]   csr_wdata  = '0;

   logic               cfg_wide;
   logic [CRC_W-1:0]   cfg_poly;
   logic [CRC_W-1:0]   cfg_init;
   logic [CRC_W-1:0]   cfg_fxor;
   logic [CRC_W-1:0]   crc_state;
   logic [CRC_W-1:0]   crc_due[$];
   logic [CRC_W-1:0]   crc_want;

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int rsp_hold      = 0;
   int mismatch_count = 0;
   int quiet_cycles  = 0;

   byte_crc8_crc16_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      if (cfg_wide) begin
         c = crc ^ {data, 8'h00};
         for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ cfg_poly) : (c << 1);
      end else begin
         c = {8'h00, crc[7:0] ^ data};
         for (int i = 0; i < 8; i++)
            c[7:0] = c[7] ? ((c[7:0] << 1) ^ cfg_poly[7:0]) : (c[7:0] << 1);
      end
      return c;
   endfunction

   function automatic logic [CRC_W-1:0] pick_word();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return CRC_W'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [CRC_W-1:0] got,
                                  input logic [CRC_W-1:0] want);
      $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Called at a falling edge; returns at a falling edge with the transfer done.
   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      crc_state = crc_fold(crc_state, data);
      if (last) begin
         crc_due.push_back(cfg_wide ? crc_state ^ cfg_fxor
                                    : {8'h00, crc_state[7:0] ^ cfg_fxor[7:0]});
         crc_state = cfg_wide ? cfg_init : {8'h00, cfg_init[7:0]};
      end
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++)
         send_byte(BYTE_W'($urandom), i == len - 1);
   endtask

   // Drop valid, let every result arrive, then let the pipeline empty.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (crc_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CRC_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      case (idx)
         REG_WIDTH_MODE: cfg_wide = value[0];
         REG_POLYNOMIAL: cfg_poly = value;
         REG_INIT_VALUE: cfg_init = value;
         REG_FINAL_XOR:  cfg_fxor = value;
      endcase
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic wide, input logic [CRC_W-1:0] poly,
                             input logic [CRC_W-1:0] init, input logic [CRC_W-1:0] fxor);
      wait_idle();
      csr_write(REG_WIDTH_MODE, {15'h0000, wide});
      csr_write(REG_POLYNOMIAL, poly);
      csr_write(REG_INIT_VALUE, init);
      csr_write(REG_FINAL_XOR, fxor);
   endtask

   task automatic test_reset_defaults();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h31, 1'b0);
      send_byte(8'h32, 1'b0);
      send_byte(8'h33, 1'b1);
   endtask

   task automatic test_crc16_ccitt();
      set_config(1'b1, 16'h1021, 16'hFFFF, 16'h0000);
      send_byte(8'h31, 1'b0);
      send_byte(8'h32, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'h34, 1'b1);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_extreme_config();
      set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      set_config(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      set_config(1'b0, 16'h0000, 16'h0000, 16'h0000);
      send_byte(8'hA5, 1'b1);
   endtask

   task automatic test_mid_message_changes();
      set_config(1'b0, 16'h1D07, 16'hABCD, 16'h00F0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hC3, 1'b0);
      wait_idle();
      csr_write(REG_WIDTH_MODE, 16'h0001);
      send_byte(8'h81, 1'b0);
      wait_idle();
      csr_write(REG_INIT_VALUE, 16'h1234);
      send_byte(8'h7E, 1'b1);
      send_byte(8'h01, 1'b0);
      wait_idle();
      csr_write(REG_WIDTH_MODE, 16'h0000);
      send_byte(8'h80, 1'b1);
      send_byte(8'h3C, 1'b1);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int n_items);
      int sent;
      int len;
      int cut;
      sent = 0;
      send_idle_pct = send_pct;
      rsp_idle_pct  = recv_pct;
      while (sent < n_items) begin
         if ($urandom_range(15) == 0)
            set_config(1'($urandom_range(1)), pick_word(), pick_word(), pick_word());
         len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
         if (len > 1 && $urandom_range(9) == 0) begin
            cut = $urandom_range(len - 1, 1);
            for (int i = 0; i < cut; i++)
               send_byte(BYTE_W'($urandom), 1'b0);
            wait_idle();
            csr_write(reg_index_type'($urandom_range(3)), CRC_W'($urandom));
            for (int i = cut; i < len; i++)
               send_byte(BYTE_W'($urandom), i == len - 1);
         end else begin
            send_message(len);
         end
         sent += len;
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      set_config(1'b1, 16'h8005, 16'h0000, 16'hFFFF);
      rsp_hold = HOLD_CYCLES;
      repeat (10) send_message($urandom_range(3, 1));
      wait_idle();
      repeat (5) send_message($urandom_range(4, 1));
   endtask

   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (crc_due.size() == 0)
            report_mismatch("result with nothing expected", rsp_tdata, 'x);
         else begin
            crc_want = crc_due.pop_front();
            if (rsp_tdata !== crc_want)
               report_mismatch("crc_value", rsp_tdata, crc_want);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL byte_crc8_crc16_engine");
         $finish;
      end
   end

   initial begin
      cfg_wide  = 1'b0;
      cfg_poly  = POLY_RESET;
      cfg_init  = INIT_RESET;
      cfg_fxor  = FXOR_RESET;
      crc_state = INIT_RESET;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_crc16_ccitt();
      test_extreme_config();
      test_mid_message_changes();
      test_random_traffic(31, 67, 165);
      test_random_traffic(67, 31, 165);
      test_random_traffic(0, 0, 170);
      test_backpressure();
      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && crc_due.size() == 0)
         $display("PASS byte_crc8_crc16_engine");
      else
         $display("FAIL byte_crc8_crc16_engine");
      $finish;
   end

endmodule
